// ----- hw/rtl/bareiss_integer_determinant_unit_macros.svh -----
// Assertion macros for the Bareiss determinant unit
`ifndef BAREISS_INTEGER_DETERMINANT_UNIT_MACROS_SVH
`define BAREISS_INTEGER_DETERMINANT_UNIT_MACROS_SVH

// Same-cycle implication under reset
`define BID_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under reset
`define BID_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bid_pkg.sv -----
// Shared types and constants of the Bareiss determinant unit
`timescale 1ns / 1ps
package bid_pkg;

  localparam int unsigned MaxSizeDefault = 8;
  localparam logic [3:0]  SizeReset      = 4'd4;
  localparam int unsigned DivSteps       = 33;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO_PIV = 2'd1,
    STAT_OVF      = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_LOAD,
    S_STG,
    S_STG_W,
    S_ROW,
    S_ROW_W,
    S_RD,
    S_RD_W,
    S_CALC,
    S_FIN,
    S_FIN_W
  } seq_state_e;

  typedef enum logic [2:0] {
    UPD_IDLE,
    UPD_MUL,
    UPD_DIFF,
    UPD_DIV,
    UPD_DONE
  } upd_state_e;

  typedef struct packed {
    logic signed [31:0] p;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
  } bid_ops_t;

  typedef struct packed {
    logic [31:0] value;
    logic        zero_div;
    logic        ovf;
  } bid_res_t;

endpackage

// ----- hw/rtl/bid_mem.sv -----
// Matrix store: one write port, two registered read ports
`timescale 1ns / 1ps
module bid_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [31:0]      wdata_i,
  input  logic [AddrW-1:0] raddr0_i,
  input  logic [AddrW-1:0] raddr1_i,
  output logic [31:0]      rdata0_o,
  output logic [31:0]      rdata1_o
);

  logic [31:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

// ----- hw/rtl/bid_upd.sv -----
// Entry update: two products, saturating difference, iterative division
`timescale 1ns / 1ps
module bid_upd (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  bid_pkg::bid_ops_t ops_i,
  output logic              done_o,
  output bid_pkg::bid_res_t res_o
);

  bid_pkg::upd_state_e state_q, state_d;
  bid_pkg::bid_ops_t   ops_q;
  logic signed [63:0]  left_q, right_q;
  logic [32:0]         rem_q, qd_q;
  logic [31:0]         dmag_q;
  logic                neg_q, big_q, dzero_q, dovf_q;
  logic [5:0]          cnt_q;

  logic signed [64:0]  diff_w;
  logic                sat_w;
  logic [63:0]         dsat_w, mag_w;
  logic [31:0]         dmag_w;
  logic [32:0]         shl_w, rem_w;
  logic                ge_w, qovf_w;

  always_comb begin
    diff_w = {left_q[63], left_q} - {right_q[63], right_q};
    sat_w  = !diff_w[64] && diff_w[63];
    dsat_w = sat_w ? 64'h7FFF_FFFF_FFFF_FFFF : diff_w[63:0];
    mag_w  = dsat_w[63] ? (~dsat_w + 64'd1) : dsat_w;
    dmag_w = ops_q.d[31] ? (~ops_q.d + 32'd1) : ops_q.d;
    // one restoring step: shift in the next dividend bit
    shl_w  = {rem_q[31:0], qd_q[32]};
    ge_w   = shl_w >= {1'b0, dmag_q};
    rem_w  = ge_w ? (shl_w - {1'b0, dmag_q}) : shl_w;
    qovf_w = big_q || (neg_q ? (qd_q > 33'h0_8000_0000) : (qd_q > 33'h0_7FFF_FFFF));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bid_pkg::UPD_IDLE: if (start_i) state_d = bid_pkg::UPD_MUL;
      bid_pkg::UPD_MUL:  state_d = bid_pkg::UPD_DIFF;
      bid_pkg::UPD_DIFF: state_d = bid_pkg::UPD_DIV;
      bid_pkg::UPD_DIV:  if (cnt_q == 6'(bid_pkg::DivSteps - 1)) state_d = bid_pkg::UPD_DONE;
      bid_pkg::UPD_DONE: state_d = bid_pkg::UPD_IDLE;
      default:           state_d = bid_pkg::UPD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bid_pkg::UPD_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      bid_pkg::UPD_IDLE: begin
        if (start_i) ops_q <= ops_i;
      end
      bid_pkg::UPD_MUL: begin
        left_q  <= 64'(ops_q.p) * 64'(ops_q.a);
        right_q <= 64'(ops_q.b) * 64'(ops_q.c);
      end
      bid_pkg::UPD_DIFF: begin
        dovf_q  <= sat_w;
        dzero_q <= ops_q.d == 32'sd0;
        neg_q   <= dsat_w[63] ^ ops_q.d[31];
        dmag_q  <= dmag_w;
        // quotient of 2^33 or more can only saturate
        big_q   <= {1'b0, mag_w[63:33]} >= dmag_w;
        rem_q   <= {3'd0, mag_w[62:33]};
        qd_q    <= mag_w[32:0];
        cnt_q   <= '0;
      end
      bid_pkg::UPD_DIV: begin
        rem_q <= rem_w;
        qd_q  <= {qd_q[31:0], ge_w};
        cnt_q <= cnt_q + 6'd1;
      end
      bid_pkg::UPD_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    done_o         = state_q == bid_pkg::UPD_DONE;
    res_o.zero_div = dzero_q;
    res_o.ovf      = dovf_q || (!dzero_q && qovf_w);
    priority if (dzero_q) begin
      res_o.value = '0;
    end else if (qovf_w) begin
      res_o.value = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      res_o.value = neg_q ? (~qd_q[31:0] + 32'd1) : qd_q[31:0];
    end
  end

endmodule

// ----- hw/rtl/bareiss_integer_determinant_unit.sv -----
// Top level: load sequencer and Bareiss elimination controller
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid_i, in_ready_o, element_i         | in
//  out      | out_valid_o, out_ready_i, determinant_o,  | out
//           | status_o                                  |
//  cfg      | cfg_we_i, cfg_wdata_i (matrix_size)       | in
//
// Loading takes one element per cycle; after the n*n-th element no input is taken
// until the result is registered. Each entry update runs the one-bit-per-cycle divider
// (33 steps); a row adds states S_ROW and S_ROW_W, a stage S_STG and S_STG_W.
// For n = 8 a matrix needs 196 entry updates.
// Reset clears control state only; the matrix store needs no clearing.
// A waiting result blocks only the next result, not the loading of the next matrix.
`timescale 1ns / 1ps
`include "bareiss_integer_determinant_unit_macros.svh"
module bareiss_integer_determinant_unit #(
  parameter int unsigned MaxSize = bid_pkg::MaxSizeDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] element_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] determinant_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i
);

  localparam int unsigned Cells = MaxSize * MaxSize;
  localparam int unsigned AW    = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int unsigned CW    = $clog2(Cells + 1);
  localparam int unsigned NW    = $clog2(MaxSize + 1);

  bid_pkg::seq_state_e state_q, state_d;
  logic [3:0]          size_q;
  logic [CW-1:0]       cnt_q, cnt_d, cnt_inc;
  logic [NW-1:0]       i_q, i_d, j_q, j_d, k_q, k_d, j_nx;
  logic [31:0]         p_q, p_d, d_q, d_d, b_q, b_d;
  logic                ovf_q, ovf_d, zdiv_q, zdiv_d;
  logic                out_valid_q, out_valid_d;
  logic [31:0]         det_q, det_d;
  logic [1:0]          stat_q, stat_d;

  logic [4:0]          size5;
  logic [NW-1:0]       n_w, nm1_w;
  logic [CW-1:0]       nn_w;
  logic                in_acc;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr, raddr0, raddr1;
  logic [31:0]         mem_wdata, rdata0, rdata1;

  logic                upd_start, upd_done;
  bid_pkg::bid_ops_t   upd_ops;
  bid_pkg::bid_res_t   upd_res;

  function automatic logic [AW-1:0] idx(logic [NW-1:0] r, logic [NW-1:0] c,
                                        logic [NW-1:0] n);
    logic [CW-1:0] s;
    s = CW'(r) * CW'(n) + CW'(c);
    return s[AW-1:0];
  endfunction

  always_comb begin
    size5 = {1'b0, size_q};
    priority if (size5 == 5'd0) begin
      n_w = NW'(1);
    end else if (size5 > 5'(MaxSize)) begin
      n_w = NW'(MaxSize);
    end else begin
      n_w = NW'(size5);
    end
    nm1_w = n_w - NW'(1);
    nn_w  = CW'(n_w) * CW'(n_w);
  end

  bid_mem #(
    .Depth (Cells),
    .AddrW (AW)
  ) u_mem (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wdata_i  (mem_wdata),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  bid_upd u_upd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (upd_start),
    .ops_i   (upd_ops),
    .done_o  (upd_done),
    .res_o   (upd_res)
  );

  assign in_ready_o = state_q == bid_pkg::S_LOAD;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    p_d         = p_q;
    d_d         = d_q;
    b_d         = b_q;
    ovf_d       = ovf_q;
    zdiv_d      = zdiv_q;
    out_valid_d = out_valid_q && !out_ready_i;
    det_d       = det_q;
    stat_d      = stat_q;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q[AW-1:0];
    mem_wdata   = element_i;
    raddr0      = idx(j_q, k_q, n_w);
    raddr1      = idx(i_q, k_q, n_w);
    upd_start   = 1'b0;
    upd_ops     = '{p: p_q, a: rdata0, b: b_q, c: rdata1, d: d_q};
    cnt_inc     = cnt_q;
    j_nx        = j_q + NW'(1);
    if (j_nx == i_q) j_nx = i_q + NW'(1);

    unique case (state_q)
      bid_pkg::S_LOAD: begin
        if (in_acc) begin
          if (cnt_q < CW'(Cells)) begin
            mem_we  = 1'b1;
            cnt_inc = cnt_q + CW'(1);
          end
          cnt_d = cnt_inc;
          if (cnt_inc >= nn_w) begin
            i_d     = '0;
            state_d = bid_pkg::S_STG;
          end
        end
      end
      bid_pkg::S_STG: begin
        raddr0 = idx(i_q, i_q, n_w);
        raddr1 = idx(i_q - NW'(1), i_q - NW'(1), n_w);
        // last stage updates nothing
        state_d = (i_q == nm1_w) ? bid_pkg::S_FIN : bid_pkg::S_STG_W;
      end
      bid_pkg::S_STG_W: begin
        p_d     = rdata0;
        d_d     = (i_q == '0) ? 32'd1 : rdata1;
        j_d     = (i_q == '0) ? NW'(1) : '0;
        state_d = bid_pkg::S_ROW;
      end
      bid_pkg::S_ROW: begin
        raddr1  = idx(j_q, i_q, n_w);
        state_d = bid_pkg::S_ROW_W;
      end
      bid_pkg::S_ROW_W: begin
        b_d     = rdata1;
        k_d     = i_q + NW'(1);
        state_d = bid_pkg::S_RD;
      end
      bid_pkg::S_RD: begin
        state_d = bid_pkg::S_RD_W;
      end
      bid_pkg::S_RD_W: begin
        upd_start = 1'b1;
        state_d   = bid_pkg::S_CALC;
      end
      bid_pkg::S_CALC: begin
        if (upd_done) begin
          mem_we    = 1'b1;
          mem_waddr = idx(j_q, k_q, n_w);
          mem_wdata = upd_res.value;
          ovf_d     = ovf_q || upd_res.ovf;
          zdiv_d    = zdiv_q || upd_res.zero_div;
          if (k_q < nm1_w) begin
            k_d     = k_q + NW'(1);
            state_d = bid_pkg::S_RD;
          end else if (j_nx >= n_w) begin
            i_d     = i_q + NW'(1);
            state_d = bid_pkg::S_STG;
          end else begin
            j_d     = j_nx;
            state_d = bid_pkg::S_ROW;
          end
        end
      end
      bid_pkg::S_FIN: begin
        raddr0  = idx(nm1_w, nm1_w, n_w);
        state_d = bid_pkg::S_FIN_W;
      end
      bid_pkg::S_FIN_W: begin
        raddr0 = idx(nm1_w, nm1_w, n_w);
        // hold until the previous result has left
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          priority if (zdiv_q) begin
            det_d  = '0;
            stat_d = bid_pkg::STAT_ZERO_PIV;
          end else if (ovf_q) begin
            det_d  = rdata0;
            stat_d = bid_pkg::STAT_OVF;
          end else begin
            det_d  = rdata0;
            stat_d = bid_pkg::STAT_OK;
          end
          cnt_d   = '0;
          ovf_d   = 1'b0;
          zdiv_d  = 1'b0;
          state_d = bid_pkg::S_LOAD;
        end
      end
      default: state_d = bid_pkg::S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bid_pkg::S_LOAD;
      size_q      <= bid_pkg::SizeReset;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      zdiv_q      <= 1'b0;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      zdiv_q      <= zdiv_d;
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      if (cfg_we_i) size_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    d_q    <= d_d;
    b_q    <= b_d;
    det_q  <= det_d;
    stat_q <= stat_d;
  end

  assign out_valid_o   = out_valid_q;
  assign determinant_o = det_q;
  assign status_o      = stat_q;

  `BID_ASSERT_IMP(a_zero_piv_det, clk_i, rst_ni, out_valid_o && status_o == bid_pkg::STAT_ZERO_PIV, determinant_o == 32'd0, "zero pivot result with nonzero determinant")
  `BID_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(Cells), "load count beyond store depth")
  `BID_ASSERT_IMP(a_wb_on_done, clk_i, rst_ni, mem_we && state_q != bid_pkg::S_LOAD, upd_done, "write-back without finished update")
  `BID_ASSERT_NXT(a_start_calc, clk_i, rst_ni, upd_start, state_q == bid_pkg::S_CALC && !upd_done, "update start not followed by wait")

endmodule
